>>> sv/ftf_pkg.sv
// ----------------------------------------------------------------------------
// ftf_pkg: shared types and constants of the FUSE transaction filter
// Transaction formats, opcode and result codes, table and queue sizes.
// ----------------------------------------------------------------------------
package ftf_pkg;

  localparam int OUTSTANDING     = 16;
  localparam int IN_HDR_BYTES    = 40;
  localparam int OUT_HDR_BYTES   = 16;
  localparam int ENTRY_OUT_BYTES = 128;
  localparam int ATTR_OUT_BYTES  = 104;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] OP_LOOKUP  = 32'd1;
  localparam logic [31:0] OP_FORGET  = 32'd2;
  localparam logic [31:0] OP_GETATTR = 32'd3;
  localparam logic [31:0] OP_OPEN    = 32'd14;
  localparam logic [31:0] OP_READ    = 32'd15;
  localparam logic [31:0] OP_WRITE   = 32'd16;
  localparam logic [31:0] OP_RELEASE = 32'd18;
  localparam logic [31:0] OP_FSYNC   = 32'd20;
  localparam logic [31:0] OP_INIT    = 32'd26;

  localparam logic [4:0] OPC_LOOKUP  = OP_LOOKUP[4:0];
  localparam logic [4:0] OPC_GETATTR = OP_GETATTR[4:0];

  localparam int                 ENOSYS         = 38;
  localparam logic signed [6:0]  REPLY_ERR_NOSYS = -7'(ENOSYS);
  localparam logic [4:0]         REPLY_LEN_NOSYS = 5'(OUT_HDR_BYTES);

  localparam logic [31:0] MODE_TYPE_MASK = 32'o170000;
  localparam logic [31:0] MODE_REGULAR   = 32'o100000;
  localparam logic [31:0] MODE_DIRECTORY = 32'o040000;

  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  localparam logic [1:0] ACT_TO_SOCKET = 2'd0;
  localparam logic [1:0] ACT_NOSYS     = 2'd1;
  localparam logic [1:0] ACT_TO_DEVICE = 2'd2;
  localparam logic [1:0] ACT_REJECT    = 2'd3;

  localparam logic [2:0] FLT_NONE       = 3'd0;
  localparam logic [2:0] FLT_BAD_HDR    = 3'd1;
  localparam logic [2:0] FLT_CONFLICT   = 3'd2;
  localparam logic [2:0] FLT_UNKNOWN_ID = 3'd3;
  localparam logic [2:0] FLT_SHORT      = 3'd4;
  localparam logic [2:0] FLT_BAD_MODE   = 3'd5;
  localparam logic [2:0] FLT_FULL       = 3'd6;
  localparam logic [2:0] FLT_STOPPED    = 3'd7;

  typedef enum logic [2:0] {
    KIND_BAD_HDR,
    KIND_FORGET,
    KIND_NOSYS,
    KIND_RECORD,
    KIND_RESPONSE
  } kind_e;

  typedef struct packed {
    logic               command;
    logic [18:0]        actual_len;
    logic [31:0]        declared_len;
    logic [31:0]        opcode;
    logic [63:0]        unique_req;
    logic signed [31:0] error_code;
    logic [31:0]        file_mode;
  } in_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        fault;
    logic [4:0]        reply_len;
    logic signed [6:0] reply_error;
    logic [63:0]       reply_unique;
  } out_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] uid;
    logic [4:0]  opc;
    logic        err_zero;
    logic        entry_len_ok;
    logic        attr_len_ok;
    logic        mode_ok;
  } cls_t;

endpackage

>>> sv/ftf_front.sv
// ----------------------------------------------------------------------------
// ftf_front: transaction classifier
// Checks header lengths and opcode class and condenses each transaction.
// ----------------------------------------------------------------------------
module ftf_front import ftf_pkg::*; (
  input  in_t  in_data_i,
  output cls_t cls_o
);

  logic [18:0] alen;
  logic [31:0] mode_type;
  logic        hdr_ok;
  logic        recorded;

  assign alen      = in_data_i.actual_len;
  assign mode_type = in_data_i.file_mode & MODE_TYPE_MASK;

  always_comb begin
    unique case (in_data_i.opcode) inside
      OP_LOOKUP, OP_GETATTR, OP_OPEN, OP_READ, OP_WRITE,
      OP_RELEASE, OP_FSYNC, OP_INIT: recorded = 1'b1;
      default: recorded = 1'b0;
    endcase
  end

  always_comb begin
    if (in_data_i.command == CMD_REQUEST) begin
      hdr_ok = (alen >= 19'(IN_HDR_BYTES));
    end else begin
      hdr_ok = (alen >= 19'(OUT_HDR_BYTES));
    end
    hdr_ok = hdr_ok && (in_data_i.declared_len == {13'd0, alen});
  end

  always_comb begin
    cls_o.uid          = in_data_i.unique_req;
    cls_o.opc          = in_data_i.opcode[4:0];
    cls_o.err_zero     = (in_data_i.error_code == 32'sd0);
    cls_o.entry_len_ok = (alen >= 19'(OUT_HDR_BYTES + ENTRY_OUT_BYTES));
    cls_o.attr_len_ok  = (alen >= 19'(OUT_HDR_BYTES + ATTR_OUT_BYTES));
    cls_o.mode_ok      = (mode_type == MODE_REGULAR) || (mode_type == MODE_DIRECTORY);
    if (!hdr_ok) begin
      cls_o.kind = KIND_BAD_HDR;
    end else if (in_data_i.command == CMD_RESPONSE) begin
      cls_o.kind = KIND_RESPONSE;
    end else if (in_data_i.opcode == OP_FORGET) begin
      cls_o.kind = KIND_FORGET;
    end else if (recorded) begin
      cls_o.kind = KIND_RECORD;
    end else begin
      cls_o.kind = KIND_NOSYS;
    end
  end

endmodule

>>> sv/ftf_queue.sv
// ----------------------------------------------------------------------------
// ftf_queue: classified transaction queue
// Short FIFO that decouples the classifier from the table stage.
// ----------------------------------------------------------------------------
module ftf_queue import ftf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t head_o
);

  cls_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/ftf_back.sv
// ----------------------------------------------------------------------------
// ftf_back: outstanding table and result stage
// Matches, records and retires transaction ids and registers the result.
// ----------------------------------------------------------------------------
module ftf_back import ftf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cls_t q_head_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [OUTSTANDING-1:0] slot_valid_q, slot_valid_d;
  logic [63:0]            slot_id_q  [OUTSTANDING];
  logic [4:0]             slot_opc_q [OUTSTANDING];
  logic                   halted_q, halted_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, res;

  logic [OUTSTANDING-1:0] match_oh, free_oh, rec_oh;
  logic                   pop, hit, has_free, do_record;
  logic [4:0]             hit_opc;
  logic [1:0]             act;
  logic [2:0]             flt;

  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_comb begin
    hit_opc = '0;
    free_oh = '0;
    for (int i = 0; i < OUTSTANDING; i++) begin
      match_oh[i] = slot_valid_q[i] && (slot_id_q[i] == q_head_i.uid);
      hit_opc     = hit_opc | (match_oh[i] ? slot_opc_q[i] : 5'd0);
    end
    for (int i = OUTSTANDING - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_oh    = '0;
        free_oh[i] = 1'b1;
      end
    end
  end

  assign hit      = |match_oh;
  assign has_free = |free_oh;

  always_comb begin
    act       = ACT_REJECT;
    flt       = FLT_STOPPED;
    do_record = 1'b0;
    slot_valid_d = slot_valid_q;
    if (!halted_q) begin
      unique case (q_head_i.kind)
        KIND_BAD_HDR: begin
          flt = FLT_BAD_HDR;
        end
        KIND_FORGET: begin
          act = ACT_TO_SOCKET;
          flt = FLT_NONE;
        end
        KIND_NOSYS: begin
          act = ACT_NOSYS;
          flt = FLT_NONE;
        end
        KIND_RECORD: begin
          if (hit) begin
            flt = FLT_CONFLICT;
          end else if (has_free) begin
            act       = ACT_TO_SOCKET;
            flt       = FLT_NONE;
            do_record = 1'b1;
          end else begin
            flt = FLT_FULL;
          end
        end
        KIND_RESPONSE: begin
          if (!hit) begin
            flt = FLT_UNKNOWN_ID;
          end else begin
            slot_valid_d = slot_valid_q & ~match_oh;
            act = ACT_TO_DEVICE;
            flt = FLT_NONE;
            if (q_head_i.err_zero &&
                ((hit_opc == OPC_LOOKUP) || (hit_opc == OPC_GETATTR))) begin
              if ((hit_opc == OPC_LOOKUP) ? !q_head_i.entry_len_ok
                                          : !q_head_i.attr_len_ok) begin
                act = ACT_REJECT;
                flt = FLT_SHORT;
              end else if (!q_head_i.mode_ok) begin
                act = ACT_REJECT;
                flt = FLT_BAD_MODE;
              end
            end
          end
        end
        default: begin
          flt = FLT_STOPPED;
        end
      endcase
    end
    rec_oh = do_record ? free_oh : '0;
    slot_valid_d = slot_valid_d | rec_oh;
  end

  always_comb begin
    res.action       = act;
    res.fault        = flt;
    res.reply_len    = (act == ACT_NOSYS) ? REPLY_LEN_NOSYS : 5'd0;
    res.reply_error  = (act == ACT_NOSYS) ? REPLY_ERR_NOSYS : 7'sd0;
    res.reply_unique = (act == ACT_NOSYS) ? q_head_i.uid : 64'd0;
  end

  always_comb begin
    halted_d    = halted_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop) begin
      out_valid_d = 1'b1;
      if (act == ACT_REJECT) begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        slot_valid_q <= slot_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
    for (int i = 0; i < OUTSTANDING; i++) begin
      if (pop && rec_oh[i]) begin
        slot_id_q[i]  <= q_head_i.uid;
        slot_opc_q[i] <= q_head_i.opc;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("stopped state cleared");

  a_stopped_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && halted_q) |=> (out_valid_q && out_q.fault == FLT_STOPPED))
    else $error("transaction after stop not reported as stopped");

  a_table_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> $stable(slot_valid_q))
    else $error("table changed without a transaction");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> $onehot0(match_oh))
    else $error("duplicate outstanding id");

endmodule

>>> sv/fuse_transaction_filter_top.sv
// ----------------------------------------------------------------------------
// fuse_transaction_filter_top: FUSE transaction filter
// Vets FUSE request and response headers against a table of open ids.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one header
//   summary per transaction: a request from the device or a response from
//   the socket. Output channel (out_valid_o / out_stall_i / out_data_o)
//   returns exactly one verdict per transaction, in order.
//   A classifier checks lengths and opcode class and pushes into a two-entry
//   queue; the table stage matches the id against 16 outstanding slots in
//   parallel and registers the verdict.
//   The verdict is valid once it has passed the queue and the result register.
//   Throughput: one transaction per cycle while the output is not stalled.
//   Reset empties the queue, frees every slot and clears the stopped state.
//   Any fault latches the stopped state; every later transaction is then
//   rejected as stopped until reset.
//   A stalled output holds its verdict; the queue keeps accepting until it
//   holds two transactions, then in_stall_o rises.
// ----------------------------------------------------------------------------
module fuse_transaction_filter_top import ftf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cls_t cls;
  cls_t q_head;
  logic q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  ftf_front u_front (
    .in_data_i (in_data_i),
    .cls_o     (cls)
  );

  ftf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ftf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: FUSE transaction filter
// Replays a short table of header summaries and then about thirteen hundred
// well-formed random transactions against a table-tracking predictor. Once
// the queue is drained, one fault of a randomly chosen kind is forced and
// random noise is sent to confirm the stopped state. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench import ftf_pkg::*; ();

  localparam int          RANDOM_ITEMS = 1300;
  localparam int          NOISE_ITEMS  = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_LEN      = 262144;
  localparam out_t        NO_VERDICT   = '0;

  typedef enum {GEN_FORGET, GEN_NOSYS, GEN_RECORD, GEN_REPLY} gen_e;
  typedef enum {INJ_BAD_HDR, INJ_CONFLICT, INJ_UNKNOWN, INJ_SHORT, INJ_MODE, INJ_FULL} inject_e;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t verdict;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  logic        slot_busy [OUTSTANDING];
  logic [63:0] slot_tag  [OUTSTANDING];
  logic [4:0]  slot_opc  [OUTSTANDING];
  logic        filter_stopped;

  logic [31:0] rec_ops [8] = '{OP_LOOKUP, OP_GETATTR, OP_OPEN, OP_READ,
                               OP_WRITE, OP_RELEASE, OP_FSYNC, OP_INIT};

  out_t        pending_verdicts [$];
  dir_row_t    plan [$];
  int unsigned errors;
  int unsigned sent;
  bit          tx_calm;
  bit          fill_mode;
  bit          valid_held;

  fuse_transaction_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit is_recorded(logic [31:0] op);
    int i;
    for (i = 0; i < 8; i++) begin
      if (rec_ops[i] == op) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit mode_ok(logic [31:0] mode);
    return ((mode & MODE_TYPE_MASK) == MODE_REGULAR) ||
           ((mode & MODE_TYPE_MASK) == MODE_DIRECTORY);
  endfunction

  function automatic int find_slot(logic [63:0] uid);
    int i;
    for (i = 0; i < OUTSTANDING; i++) begin
      if (slot_busy[i] && slot_tag[i] == uid) return i;
    end
    return -1;
  endfunction

  function automatic int busy_count();
    int i;
    int n;
    n = 0;
    for (i = 0; i < OUTSTANDING; i++) n += int'(slot_busy[i]);
    return n;
  endfunction

  function automatic int busy_pick();
    int s;
    do s = $urandom_range(0, OUTSTANDING - 1); while (!slot_busy[s]);
    return s;
  endfunction

  function automatic out_t pack_verdict(logic [1:0] act, logic [2:0] flt, logic [63:0] uid);
    out_t v;
    v = '0;
    v.action = act;
    v.fault  = flt;
    if (act == ACT_NOSYS) begin
      v.reply_len    = 5'(OUT_HDR_BYTES);
      v.reply_error  = 7'(-ENOSYS);
      v.reply_unique = uid;
    end
    return v;
  endfunction

  function automatic out_t filter_verdict(in_t t);
    int          hit;
    int          vacant;
    int          i;
    logic [31:0] need;
    out_t        v;
    hit    = find_slot(t.unique_req);
    vacant = -1;
    for (i = OUTSTANDING - 1; i >= 0; i--) begin
      if (!slot_busy[i]) vacant = i;
    end
    if (filter_stopped) begin
      v = pack_verdict(ACT_REJECT, FLT_STOPPED, '0);
    end else if (t.command == CMD_REQUEST) begin
      if (t.actual_len < IN_HDR_BYTES || t.declared_len != 32'(t.actual_len)) begin
        v = pack_verdict(ACT_REJECT, FLT_BAD_HDR, '0);
      end else if (t.opcode == OP_FORGET) begin
        v = pack_verdict(ACT_TO_SOCKET, FLT_NONE, '0);
      end else if (!is_recorded(t.opcode)) begin
        v = pack_verdict(ACT_NOSYS, FLT_NONE, t.unique_req);
      end else if (hit >= 0) begin
        v = pack_verdict(ACT_REJECT, FLT_CONFLICT, '0);
      end else if (vacant < 0) begin
        v = pack_verdict(ACT_REJECT, FLT_FULL, '0);
      end else begin
        slot_busy[vacant] = 1'b1;
        slot_tag[vacant]  = t.unique_req;
        slot_opc[vacant]  = t.opcode[4:0];
        v = pack_verdict(ACT_TO_SOCKET, FLT_NONE, '0);
      end
    end else begin
      if (t.actual_len < OUT_HDR_BYTES || t.declared_len != 32'(t.actual_len)) begin
        v = pack_verdict(ACT_REJECT, FLT_BAD_HDR, '0);
      end else if (hit < 0) begin
        v = pack_verdict(ACT_REJECT, FLT_UNKNOWN_ID, '0);
      end else begin
        slot_busy[hit] = 1'b0;
        need = '0;
        if (t.error_code == 0) begin
          if (slot_opc[hit] == OPC_LOOKUP) need = OUT_HDR_BYTES + ENTRY_OUT_BYTES;
          else if (slot_opc[hit] == OPC_GETATTR) need = OUT_HDR_BYTES + ATTR_OUT_BYTES;
        end
        if (need != 0 && 32'(t.actual_len) < need) begin
          v = pack_verdict(ACT_REJECT, FLT_SHORT, '0);
        end else if (need != 0 && !mode_ok(t.file_mode)) begin
          v = pack_verdict(ACT_REJECT, FLT_BAD_MODE, '0);
        end else begin
          v = pack_verdict(ACT_TO_DEVICE, FLT_NONE, '0);
        end
      end
    end
    if (v.action == ACT_REJECT) filter_stopped = 1'b1;
    return v;
  endfunction

  function automatic int unsigned gap_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [18:0] pick_len(int unsigned lo);
    if ($urandom_range(0, 15) == 0) return 19'($urandom_range(lo, MAX_LEN));
    return 19'($urandom_range(lo, lo + 600));
  endfunction

  function automatic logic [31:0] rec_op();
    if ($urandom_range(0, 4) < 2) return $urandom_range(0, 1) ? OP_LOOKUP : OP_GETATTR;
    return rec_ops[$urandom_range(0, 7)];
  endfunction

  function automatic logic [63:0] fresh_id();
    logic [63:0] u;
    do begin
      u = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 63)) : rand64();
    end while (find_slot(u) >= 0);
    return u;
  endfunction

  function automatic logic [31:0] good_mode();
    return ($urandom & ~MODE_TYPE_MASK) |
           ($urandom_range(0, 1) ? MODE_REGULAR : MODE_DIRECTORY);
  endfunction

  function automatic in_t random_item();
    in_t t;
    t.command      = 1'($urandom_range(0, 1));
    t.actual_len   = 19'($urandom_range(0, MAX_LEN));
    t.declared_len = $urandom_range(0, 1) ? 32'(t.actual_len) : $urandom;
    t.opcode       = $urandom;
    t.unique_req   = rand64();
    t.error_code   = $urandom;
    t.file_mode    = $urandom;
    return t;
  endfunction

  function automatic in_t make_record(logic [31:0] op, logic [63:0] uid);
    in_t t;
    t              = random_item();
    t.command      = CMD_REQUEST;
    t.opcode       = op;
    t.unique_req   = uid;
    t.actual_len   = pick_len(IN_HDR_BYTES);
    t.declared_len = 32'(t.actual_len);
    return t;
  endfunction

  function automatic in_t gen_clean();
    in_t         t;
    gen_e        k;
    int          n;
    int          s;
    int unsigned r;
    int unsigned floor_len;
    logic [31:0] op;
    n = busy_count();
    r = $urandom_range(0, 99);
    if (r < 8)                          k = GEN_FORGET;
    else if (r < 20)                    k = GEN_NOSYS;
    else if (r < (fill_mode ? 75 : 40)) k = GEN_RECORD;
    else                                k = GEN_REPLY;
    if (n == OUTSTANDING && k == GEN_RECORD) k = GEN_REPLY;
    if (n == 0 && k == GEN_REPLY) k = GEN_RECORD;
    t = random_item();
    t.command      = CMD_REQUEST;
    t.actual_len   = pick_len(IN_HDR_BYTES);
    t.declared_len = 32'(t.actual_len);
    case (k)
      GEN_FORGET: begin
        t.opcode = OP_FORGET;
      end
      GEN_NOSYS: begin
        do begin
          op = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 40)) : $urandom;
        end while (op == OP_FORGET || is_recorded(op));
        t.opcode = op;
      end
      GEN_RECORD: begin
        t = make_record(rec_op(), fresh_id());
      end
      default: begin
        s = busy_pick();
        t.command    = CMD_RESPONSE;
        t.unique_req = slot_tag[s];
        floor_len    = OUT_HDR_BYTES;
        if ($urandom_range(0, 1)) t.error_code = 0;
        else if (t.error_code == 0) t.error_code = 1;
        if (t.error_code == 0 && (slot_opc[s] == OPC_LOOKUP || slot_opc[s] == OPC_GETATTR)) begin
          floor_len   = OUT_HDR_BYTES +
                        (slot_opc[s] == OPC_LOOKUP ? ENTRY_OUT_BYTES : ATTR_OUT_BYTES);
          t.file_mode = good_mode();
        end
        t.actual_len   = pick_len(floor_len);
        t.declared_len = 32'(t.actual_len);
      end
    endcase
    return t;
  endfunction

  function automatic dir_row_t drow(logic cmd, logic [18:0] alen, logic [31:0] op,
                                    logic [63:0] uid, logic [31:0] err, logic [31:0] mode,
                                    bit typed, out_t v);
    dir_row_t r;
    r.item.command      = cmd;
    r.item.actual_len   = alen;
    r.item.declared_len = 32'(alen);
    r.item.opcode       = op;
    r.item.unique_req   = uid;
    r.item.error_code   = err;
    r.item.file_mode    = mode;
    r.typed             = typed;
    r.verdict           = v;
    return r;
  endfunction

  task automatic send_item(input in_t t, input bit typed, input out_t typed_v);
    out_t        v;
    int unsigned g;
    in_data_i  <= t;
    in_valid_i <= 1'b1;
    valid_held  = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    v = filter_verdict(t);
    pending_verdicts.push_back(typed ? typed_v : v);
    sent++;
    if (sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    g = gap_len(tx_calm);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      valid_held  = 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held  = 1'b0;
    end
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_t        want;
    out_t        got;
    int unsigned stall_left;
    int unsigned span;
    bit          rx_calm;
    stall_left   = 0;
    span         = 0;
    rx_calm      = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = out_data_o;
        if (pending_verdicts.size() == 0) begin
          $error("verdict with nothing pending: action %0d fault %0d", got.action, got.fault);
          errors++;
        end else begin
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          if (got.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got.action);
            errors++;
          end
          if (got.fault !== want.fault) begin
            $error("fault: expected %0d, actual %0d", want.fault, got.fault);
            errors++;
          end
          if (got.reply_len !== want.reply_len) begin
            $error("reply_len: expected %0d, actual %0d", want.reply_len, got.reply_len);
            errors++;
          end
          if (got.reply_error !== want.reply_error) begin
            $error("reply_error: expected %0d, actual %0d", want.reply_error, got.reply_error);
            errors++;
          end
          if (got.reply_unique !== want.reply_unique) begin
            $error("reply_unique: expected %h, actual %h", want.reply_unique, got.reply_unique);
            errors++;
          end
        end
      end
      if (span == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        span    = $urandom_range(100, 400);
      end
      span--;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = gap_len(rx_calm);
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    in_t         t;
    inject_e     fk;
    int          k;
    int unsigned floor_len;
    logic [63:0] u;
    logic [31:0] op;
    logic [31:0] m;
    errors         = 0;
    sent           = 0;
    tx_calm        = 1'b0;
    fill_mode      = 1'b0;
    valid_held     = 1'b0;
    filter_stopped = 1'b0;
    for (k = 0; k < OUTSTANDING; k++) begin
      slot_busy[k] = 1'b0;
      slot_tag[k]  = '0;
      slot_opc[k]  = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;

    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_FORGET, '0, '0, '0,
                        1'b1, pack_verdict(ACT_TO_SOCKET, FLT_NONE, '0)));
    plan.push_back(drow(CMD_REQUEST, 19'd40, 32'd0, '1, '1, '1,
                        1'b1, pack_verdict(ACT_NOSYS, FLT_NONE, '1)));
    plan.push_back(drow(CMD_REQUEST, 19'(MAX_LEN), '1, 64'h8000_0000_0000_0001, '0, '0,
                        1'b1, pack_verdict(ACT_NOSYS, FLT_NONE, 64'h8000_0000_0000_0001)));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_INIT, 64'd1, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd64, OP_LOOKUP, 64'd2, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd100, OP_GETATTR, 64'd3, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_OPEN, 64'd4, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd41, OP_READ, 64'd5, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd4096, OP_WRITE, 64'd6, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_RELEASE, 64'd7, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'(MAX_LEN), OP_FSYNC, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0,
                        1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, 32'd34, 64'd8, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, 32'd33, 64'd9, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd144, '0, 64'd2, '0, 32'o100644, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd120, '0, 64'd3, '0, 32'o040755, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd16, '0, 64'd1, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_LOOKUP, 64'd10, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd16, '0, 64'd10, 32'hFFFF_FFFE, '0, 1'b0,
                        NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_GETATTR, 64'd11, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd16, '0, 64'd11, 32'h8000_0000, '1, 1'b0,
                        NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'd16, '0, 64'd4, 32'h7FFF_FFFF, '0, 1'b0,
                        NO_VERDICT));
    plan.push_back(drow(CMD_REQUEST, 19'd40, OP_OPEN, 64'd4, '0, '0, 1'b0, NO_VERDICT));
    plan.push_back(drow(CMD_RESPONSE, 19'(MAX_LEN), '0, 64'hFFFF_FFFF_FFFF_FFFE, '0,
                        32'o170000, 1'b0, NO_VERDICT));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].verdict);
    wait_drained();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) fill_mode = $urandom_range(0, 1);
      if (k == RANDOM_ITEMS / 2) wait_drained();
      send_item(gen_clean(), 1'b0, NO_VERDICT);
    end
    wait_drained();

    // force one fault, then confirm the stopped state
    fk = inject_e'($urandom_range(0, 5));
    case (fk)
      INJ_BAD_HDR: begin
        t = random_item();
        floor_len = (t.command == CMD_REQUEST) ? IN_HDR_BYTES : OUT_HDR_BYTES;
        if ($urandom_range(0, 1)) begin
          t.actual_len   = 19'($urandom_range(0, floor_len - 1));
          t.declared_len = 32'(t.actual_len);
        end else begin
          t.actual_len   = pick_len(floor_len);
          t.declared_len = 32'(t.actual_len) ^ ($urandom | 32'd1);
        end
      end
      INJ_CONFLICT: begin
        if (busy_count() == 0) send_item(make_record(rec_op(), fresh_id()), 1'b0, NO_VERDICT);
        t = make_record(rec_op(), slot_tag[busy_pick()]);
      end
      INJ_UNKNOWN: begin
        t              = random_item();
        t.command      = CMD_RESPONSE;
        t.unique_req   = fresh_id();
        t.actual_len   = pick_len(OUT_HDR_BYTES);
        t.declared_len = 32'(t.actual_len);
      end
      INJ_SHORT, INJ_MODE: begin
        while (busy_count() == OUTSTANDING) send_item(gen_clean(), 1'b0, NO_VERDICT);
        u  = fresh_id();
        op = $urandom_range(0, 1) ? OP_LOOKUP : OP_GETATTR;
        send_item(make_record(op, u), 1'b0, NO_VERDICT);
        floor_len = OUT_HDR_BYTES + (op == OP_LOOKUP ? ENTRY_OUT_BYTES : ATTR_OUT_BYTES);
        t            = random_item();
        t.command    = CMD_RESPONSE;
        t.unique_req = u;
        t.error_code = 0;
        if (fk == INJ_SHORT) begin
          t.actual_len = 19'($urandom_range(OUT_HDR_BYTES, floor_len - 1));
        end else begin
          t.actual_len = pick_len(floor_len);
          do m = $urandom; while (mode_ok(m));
          t.file_mode = m;
        end
        t.declared_len = 32'(t.actual_len);
      end
      default: begin
        while (busy_count() < OUTSTANDING) begin
          send_item(make_record(rec_op(), fresh_id()), 1'b0, NO_VERDICT);
        end
        if ($urandom_range(0, 1)) t = make_record(rec_op(), fresh_id());
        else t = make_record(rec_op(), slot_tag[busy_pick()]);
      end
    endcase
    send_item(t, 1'b0, NO_VERDICT);

    for (k = 0; k < NOISE_ITEMS; k++) send_item(random_item(), 1'b0, NO_VERDICT);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> fuse_transaction_filter_top.f
sv/ftf_pkg.sv
sv/ftf_front.sv
sv/ftf_queue.sv
sv/ftf_back.sv
sv/fuse_transaction_filter_top.sv
sim/testbench.sv
